// ===== hdl/imt_pkg.sv =====
// shared types and constants for the interval membership table
// holds the table depth, the token passed along the cell chain and the fsm states
// no dependencies
`default_nettype none

package imt_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DATA_W  = 32;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // pass kinds carried by the token
    typedef enum logic [1:0] {
        OP_FIND,
        OP_COMMIT,
        OP_QUERY
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_COMMIT,
        S_QUERY,
        S_DONE
    } t_state;

    // token walking down the chain, one cell per cycle
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [DATA_W-1:0] key_a;   // range start, or query value
        logic [DATA_W-1:0] key_b;   // range end
        logic              found;   // free entry found on the find pass
        logic [IDX_W-1:0]  slot;
        logic              s_ok;    // best start candidate so far
        logic [DATA_W-1:0] s_val;
        logic [IDX_W-1:0]  s_idx;
        logic              e_ok;    // best end candidate so far
        logic [DATA_W-1:0] e_val;
        logic [IDX_W-1:0]  e_idx;
    } t_tok;

endpackage

`default_nettype wire

// ===== hdl/imt_cell.sv =====
// one table entry of the interval membership table with its token stage
// depends on imt_pkg
`default_nettype none

module imt_cell
    import imt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_tok             i_tok,
    output t_tok                  o_tok
);

    logic [DATA_W-1:0] r_start;
    logic [DATA_W-1:0] r_end;
    logic              r_slive;
    logic              r_elive;
    t_tok              r_tok;

    t_tok              n_tok;
    logic              n_slive;
    logic              n_elive;
    logic              w_write;

    logic              w_s_match;
    logic              w_e_match;
    logic              w_free;
    logic              w_s_cand;
    logic              w_e_cand;

    assign w_s_match = r_slive && (r_start == i_tok.key_a);
    assign w_e_match = r_elive && (r_end == i_tok.key_b);
    // free once matching older marks would be cleared
    assign w_free    = (!r_slive || w_s_match) && (!r_elive || w_e_match);

    assign w_s_cand = r_slive
                   && ($signed(r_start) <= $signed(i_tok.key_a))
                   && (!i_tok.s_ok || ($signed(r_start) > $signed(i_tok.s_val)));
    assign w_e_cand = r_elive
                   && ($signed(r_end) >= $signed(i_tok.key_a))
                   && (!i_tok.e_ok || ($signed(r_end) < $signed(i_tok.e_val)));

    always_comb begin
        n_tok   = i_tok;
        n_slive = r_slive;
        n_elive = r_elive;
        w_write = 1'b0;
        if (i_tok.valid) begin
            case (i_tok.op)
                OP_FIND: begin
                    if (!i_tok.found && w_free) begin
                        n_tok.found = 1'b1;
                        n_tok.slot  = i_idx;
                    end
                end
                OP_COMMIT: begin
                    if (w_s_match) n_slive = 1'b0;
                    if (w_e_match) n_elive = 1'b0;
                    if (i_tok.slot == i_idx) begin
                        w_write = 1'b1;
                        n_slive = 1'b1;
                        n_elive = 1'b1;
                    end
                end
                OP_QUERY: begin
                    if (w_s_cand) begin
                        n_tok.s_ok  = 1'b1;
                        n_tok.s_val = r_start;
                        n_tok.s_idx = i_idx;
                    end
                    if (w_e_cand) begin
                        n_tok.e_ok  = 1'b1;
                        n_tok.e_val = r_end;
                        n_tok.e_idx = i_idx;
                    end
                end
                default: begin
                    n_tok = i_tok;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slive     <= 1'b0;
            r_elive     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_slive <= n_slive;
            r_elive <= n_elive;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_start <= i_tok.key_a;
            r_end   <= i_tok.key_b;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== hdl/imt_ctrl.sv =====
// sequencer of the interval membership table: injects tokens, collects them
// at the chain end and holds the result register; depends on imt_pkg
`default_nettype none

module imt_ctrl
    import imt_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_func,
    input  wire logic signed [DATA_W-1:0] i_range_low,
    input  wire logic signed [DATA_W-1:0] i_range_high,
    input  wire logic signed [DATA_W-1:0] i_query_value,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_inside_res,
    output logic                          o_dropped,
    output t_tok                          o_inj,
    input  wire t_tok                     i_tail
);

    t_state r_state;
    t_state n_state;
    t_tok   r_inj;
    t_tok   n_inj;
    logic   r_pend_inside;
    logic   n_pend_inside;
    logic   r_pend_dropped;
    logic   n_pend_dropped;
    logic   r_out_valid;
    logic   r_out_inside;
    logic   r_out_dropped;
    logic   w_out_load;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = (i_func == FUNC_QUERY) ? S_QUERY : S_FIND;
            end
            S_FIND: begin
                if (i_tail.valid) n_state = i_tail.found ? S_COMMIT : S_DONE;
            end
            S_COMMIT: begin
                if (i_tail.valid) n_state = S_DONE;
            end
            S_QUERY: begin
                if (i_tail.valid) n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        n_inj          = '0;
        n_pend_inside  = r_pend_inside;
        n_pend_dropped = r_pend_dropped;
        w_out_load     = 1'b0;
        o_ready        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_inj.valid = 1'b1;
                    if (i_func == FUNC_QUERY) begin
                        n_inj.op    = OP_QUERY;
                        n_inj.key_a = i_query_value;
                    end else begin
                        n_inj.op    = OP_FIND;
                        n_inj.key_a = i_range_low;
                        n_inj.key_b = i_range_high;
                    end
                end
            end
            S_FIND: begin
                if (i_tail.valid) begin
                    if (i_tail.found) begin
                        n_inj    = i_tail;
                        n_inj.op = OP_COMMIT;
                    end else begin
                        n_pend_inside  = 1'b0;
                        n_pend_dropped = 1'b1;
                    end
                end
            end
            S_COMMIT: begin
                if (i_tail.valid) begin
                    n_pend_inside  = 1'b0;
                    n_pend_dropped = 1'b0;
                end
            end
            S_QUERY: begin
                if (i_tail.valid) begin
                    n_pend_inside  = i_tail.s_ok && i_tail.e_ok
                                  && (i_tail.s_idx == i_tail.e_idx);
                    n_pend_dropped = 1'b0;
                end
            end
            S_DONE: begin
                w_out_load = !r_out_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_inj.valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_inj   <= n_inj;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_inside  <= n_pend_inside;
        r_pend_dropped <= n_pend_dropped;
        if (w_out_load) begin
            r_out_inside  <= r_pend_inside;
            r_out_dropped <= r_pend_dropped;
        end
    end

    assign o_inj        = r_inj;
    assign o_valid      = r_out_valid;
    assign o_inside_res = r_out_inside;
    assign o_dropped    = r_out_dropped;

endmodule

`default_nettype wire

// ===== hdl/interval_membership_table_top.sv =====
// top level of the interval membership table: sequencer plus a chain of
// ENTRIES cells; depends on imt_pkg, imt_cell and imt_ctrl
`default_nettype none

// how the block is used
// - input channel i_valid/o_ready carries one item: i_func selects an add
//   (range i_range_low..i_range_high, signed, inclusive) or a query of
//   i_query_value
// - output channel o_valid/i_ready returns exactly one item per input item:
//   o_inside_res for queries, o_dropped when an add finds the table full
// - one item is worked on at a time; a token walks the cell chain, one cell
//   per cycle, each cell holding one table entry
// - a query takes one pass: the tail result is held in the sequencer, then
//   loaded into the output register; the next item can be taken in the same
//   cycle as o_valid rises
// - an add takes a find pass for the lowest free entry and then a commit pass
//   that clears older matching marks and writes the entry; a full table skips
//   the commit pass and takes as long as a query
// - the chain length sets how long a pass takes; the next item is taken as
//   soon as the result is in the output register, even while the receiver stalls
// - with the output register still full the finished result waits in the
//   sequencer and no new item is taken
// - reset clears all live marks, the token stages and the output register;
//   stored range values are not cleared, they are read only under a live mark

module interval_membership_table_top
    import imt_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic                     i_func,
    input  wire logic signed [DATA_W-1:0] i_range_low,
    input  wire logic signed [DATA_W-1:0] i_range_high,
    input  wire logic signed [DATA_W-1:0] i_query_value,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic                          o_inside_res,
    output logic                          o_dropped
);

    // chain links: element 0 is the injected token, the last is the tail
    t_tok w_chain [ENTRIES+1];

    imt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .i_query_value (i_query_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_inside_res  (o_inside_res),
        .o_dropped     (o_dropped),
        .o_inj         (w_chain[0]),
        .i_tail        (w_chain[ENTRIES])
    );

    // one cell per table entry, each knows its own index
    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        imt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(gi)),
            .i_tok   (w_chain[gi]),
            .o_tok   (w_chain[gi+1])
        );
    end

endmodule

`default_nettype wire
